>>> hw/rtl/lmmb_pkg.sv
// Shared types and constants for the local median min/max binarizer.
package lmmb_pkg;

  // Pixel and frame dimension widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIM_W      = 13;   // holds widths up to 4096 and heights up to 4096
  localparam int unsigned ROW_W      = 12;   // row position, below 4096
  localparam int unsigned WIDTH_W    = 11;   // image_width register
  localparam int unsigned HEIGHT_W   = 13;   // image_height register
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Reset values of the configuration registers
  localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd512;
  localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 13'd512;

  typedef logic [PIX_W-1:0] pix_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic valid;
    logic emit;   // window is fully inside the frame
    logic last;   // final interior pixel of the frame
  } ctrl_t;

endpackage

>>> hw/rtl/lmmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lmmb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same address is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/local_median_min_max_binarize_top.sv
// Top level of the local median min/max binarizer: line buffers, window and ranking pipeline.
//
// Gray pixels come in raster order, one per clock while in_stall is low. A square window of
// 2*WINDOW_RADIUS+1 pixels on a side slides over the frame; for every
// interior position the block emits the window maximum when the center pixel
// is at least the window median, else the window minimum. Border positions
// give no output; frame_last marks the last interior pixel of a frame. The
// sustained rate is one pixel per clock while no result waits on out_stall;
// a result is registered in turn by the line buffer read, window shift,
// rank compare and output registers after the pixel that completes its window.
// A result held by out_stall freezes the whole pipeline and stalls the input.
// The previous 2*WINDOW_RADIUS rows sit
// in one MAX_WIDTH-deep RAM per row, all read at the current column while the
// pipeline advances. No clearing pass is needed after reset: rows are written
// before they are used inside a frame. Write image_width and image_height only when
// the block is idle; a size change mid-frame takes effect at the next pixel: a
// column past the new width opens the next row, a row past the new height a new frame.
module local_median_min_max_binarize_top #(
  parameter int unsigned WINDOW_RADIUS = 1,
  parameter int unsigned MAX_WIDTH     = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [lmmb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lmmb_pkg::CFG_DATA_W-1:0]     cfg_data,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lmmb_pkg::PIX_W-1:0]          pixel_in,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lmmb_pkg::PIX_W-1:0]          pixel_out,
  output logic                                frame_last
);

  import lmmb_pkg::*;

  localparam int unsigned WIN_D     = 2 * WINDOW_RADIUS + 1;
  localparam int unsigned WIN_N     = WIN_D * WIN_D;
  localparam int unsigned LINE_ROWS = 2 * WINDOW_RADIUS;
  localparam int unsigned SLOT_W    = $clog2(LINE_ROWS);
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W     = $clog2(WIN_N + 1);
  localparam int unsigned MED_RANK  = WIN_N / 2;
  localparam int unsigned CTR_IDX   = WINDOW_RADIUS * WIN_D + WINDOW_RADIUS;

  localparam logic [DIM_W-1:0] MAX_W_D   = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_D   = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] ROWS_D    = DIM_W'(LINE_ROWS);
  localparam logic [CNT_W-1:0] MED_RANK_C = CNT_W'(MED_RANK);
  localparam logic [CNT_W-1:0] WIN_N_C    = CNT_W'(WIN_N);

  // Configuration and position registers
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [COL_W-1:0]    column_count_next;
  logic [ROW_W-1:0]    row_count_next;

  // Pipeline
  logic                advance;
  logic                accept;
  ctrl_t               ctrl_in;
  ctrl_t               s1;
  pix_t                px1;
  logic [SLOT_W-1:0]   slot1;
  ctrl_t               s2;
  pix_t                win [WIN_D][WIN_D];
  logic                s3_valid;
  logic                s3_last;
  pix_t                vals3 [WIN_N];
  logic [WIN_N-1:0]    med_flag3;
  logic [WIN_N-1:0]    min_flag3;
  logic [WIN_N-1:0]    max_flag3;

  // Position arithmetic
  logic [DIM_W-1:0]    eff_w;
  logic [DIM_W-1:0]    eff_h;
  logic [DIM_W-1:0]    col_cur;
  logic [DIM_W-1:0]    row_cur;
  logic [DIM_W-1:0]    col_inc;
  logic [DIM_W-1:0]    row_inc;
  logic [DIM_W-1:0]    col_after;
  logic [DIM_W-1:0]    row_after;
  logic [SLOT_W-1:0]   slot_cur;

  // Line buffer
  pix_t                line_rd [LINE_ROWS];

  // Ranking
  pix_t                vals_c [WIN_N];
  logic [WIN_N-1:0]    lt_vec [WIN_N];
  logic [WIN_N-1:0]    le_vec [WIN_N];
  logic [CNT_W-1:0]    lt_cnt [WIN_N];
  logic [CNT_W-1:0]    le_cnt [WIN_N];
  logic [WIN_N-1:0]    med_flag_c;
  logic [WIN_N-1:0]    min_flag_c;
  logic [WIN_N-1:0]    max_flag_c;

  // Selection
  pix_t                med_sel;
  pix_t                min_sel;
  pix_t                max_sel;
  pix_t                result_c;

  // Handshake: whole pipeline moves unless a result waits on a stalled output
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to the supported range
  always_comb begin
    if (image_width == '0) begin
      eff_w = DIM_W'(1);
    end else if ({{(DIM_W-WIDTH_W){1'b0}}, image_width} > MAX_W_D) begin
      eff_w = MAX_W_D;
    end else begin
      eff_w = {{(DIM_W-WIDTH_W){1'b0}}, image_width};
    end
    if (image_height == '0) begin
      eff_h = DIM_W'(1);
    end else if (image_height > MAX_H_D) begin
      eff_h = MAX_H_D;
    end else begin
      eff_h = image_height;
    end
  end

  // Position of the arriving pixel and of the one after it
  always_comb begin
    col_cur = {{(DIM_W-COL_W){1'b0}}, column_count};
    row_cur = {{(DIM_W-ROW_W){1'b0}}, row_count};
    if (col_cur >= eff_w) begin
      col_cur = '0;
      row_cur = row_cur + DIM_W'(1);
    end
    if (row_cur >= eff_h) begin
      row_cur = '0;
    end
    col_inc = col_cur + DIM_W'(1);
    row_inc = row_cur + DIM_W'(1);
    if (col_inc >= eff_w) begin
      col_after = '0;
      row_after = (row_inc >= eff_h) ? '0 : row_inc;
    end else begin
      col_after = col_inc;
      row_after = row_cur;
    end
    column_count_next = col_after[COL_W-1:0];
    row_count_next    = row_after[ROW_W-1:0];
    slot_cur          = row_cur[SLOT_W-1:0];
    ctrl_in.valid     = 1'b1;
    ctrl_in.emit      = (row_cur >= ROWS_D) && (col_cur >= ROWS_D);
    ctrl_in.last      = (row_cur == eff_h - DIM_W'(1)) && (col_cur == eff_w - DIM_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Line buffer: one RAM per stored row, all read at the current column
  for (genvar k = 0; k < LINE_ROWS; k++) begin : g_line
    lmmb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line_ram (
      .clk   (clk),
      .we    (accept && (slot_cur == SLOT_W'(k))),
      .waddr (col_cur[COL_W-1:0]),
      .wdata (pixel_in),
      .re    (advance),
      .raddr (col_cur[COL_W-1:0]),
      .rdata (line_rd[k])
    );
  end

  // Stage 1: pixel and control wait for the line buffer read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (advance) begin
      s1       <= accept ? ctrl_in : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      px1   <= pixel_in;
      slot1 <= slot_cur;
    end
  end

  // Stage 2: shift the window left and load the new right column
  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else if (advance) begin
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1.valid) begin
      for (int a = 0; a < WIN_D; a++) begin
        for (int b = 0; b < WIN_D - 1; b++) begin
          win[a][b] <= win[a][b+1];
        end
      end
      for (int a = 0; a < LINE_ROWS; a++) begin
        win[a][WIN_D-1] <= line_rd[slot1 + SLOT_W'(a)];
      end
      win[WIN_D-1][WIN_D-1] <= px1;
    end
  end

  // Rank every window sample against all others
  always_comb begin
    for (int a = 0; a < WIN_D; a++) begin
      for (int b = 0; b < WIN_D; b++) begin
        vals_c[a*WIN_D + b] = win[a][b];
      end
    end
    for (int i = 0; i < WIN_N; i++) begin
      for (int j = 0; j < WIN_N; j++) begin
        lt_vec[i][j] = vals_c[j] < vals_c[i];
        le_vec[i][j] = vals_c[j] <= vals_c[i];
      end
      lt_cnt[i]     = CNT_W'($countones(lt_vec[i]));
      le_cnt[i]     = CNT_W'($countones(le_vec[i]));
      med_flag_c[i] = (lt_cnt[i] <= MED_RANK_C) && (le_cnt[i] > MED_RANK_C);
      min_flag_c[i] = (lt_cnt[i] == '0);
      max_flag_c[i] = (le_cnt[i] == WIN_N_C);
    end
  end

  // Stage 3: ranking flags and window copy
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2.valid && s2.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_last   <= s2.last;
      vals3     <= vals_c;
      med_flag3 <= med_flag_c;
      min_flag3 <= min_flag_c;
      max_flag3 <= max_flag_c;
    end
  end

  // Pick median, minimum and maximum and select the result; tied samples share one value
  always_comb begin
    med_sel = '0;
    min_sel = '0;
    max_sel = '0;
    for (int i = 0; i < WIN_N; i++) begin
      med_sel = med_sel | (vals3[i] & {PIX_W{med_flag3[i]}});
      min_sel = min_sel | (vals3[i] & {PIX_W{min_flag3[i]}});
      max_sel = max_sel | (vals3[i] & {PIX_W{max_flag3[i]}});
    end
    result_c = (vals3[CTR_IDX] >= med_sel) ? max_sel : min_sel;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_out  <= result_c;
      frame_last <= s3_last;
    end
  end

  // Checks
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    column_count < COL_W'(MAX_WIDTH - 1) || column_count == COL_W'(MAX_WIDTH - 1))
    else $error("column count beyond line buffer depth");

  a_rank_found: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> ((|med_flag3) && (|min_flag3) && (|max_flag3)))
    else $error("no median, minimum or maximum found in window");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(s1) && $stable(s2) && $stable(s3_valid)))
    else $error("pipeline moved while output stalled");

  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    (advance && s2.valid && !s2.emit) |=> !s3_valid)
    else $error("border position reached the ranking stage");

endmodule

>>> tb/local_median_min_max_binarize_top_tb.sv
// Self-checking testbench for the local median min/max binarizer top level.
module local_median_min_max_binarize_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmmb_pkg::*;

  localparam int unsigned WIN_R     = 1;
  localparam int unsigned MAX_W     = 1024;
  localparam int unsigned WIN_D     = 2 * WIN_R + 1;
  localparam int unsigned WIN_N     = WIN_D * WIN_D;
  localparam int unsigned LINE_ROWS = 2 * WIN_R;

  // Pixel value patterns for frame content
  typedef enum int {PAT_UNIFORM, PAT_TIES, PAT_BINARY, PAT_GRADIENT} pattern_t;

  // One expected output transfer
  typedef struct packed {
    pix_t pix;
    logic frame_end;
  } binarized_t;

  logic                  clk;
  logic                  rst        = 1'b1;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  pix_t                  pixel_in   = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  pix_t                  pixel_out;
  logic                  frame_last;

  local_median_min_max_binarize_top #(
    .WINDOW_RADIUS(WIN_R),
    .MAX_WIDTH    (MAX_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out),
    .frame_last(frame_last)
  );

  // Binarizer state mirror
  logic [WIDTH_W-1:0]  cfg_width  = IMAGE_WIDTH_RST;
  logic [HEIGHT_W-1:0] cfg_height = IMAGE_HEIGHT_RST;
  pix_t                line_mem [LINE_ROWS][MAX_W];
  pix_t                win_regs [WIN_D][WIN_D];
  int unsigned         col_pos = 0;
  int unsigned         row_pos = 0;

  pix_t       pixel_q[$];      // pixels waiting to be offered
  binarized_t expected_q[$];   // binarized results still to come

  // Run bookkeeping
  int  mismatches      = 0;
  int  pixels_sent     = 0;
  int  results_checked = 0;
  int  frames_sent     = 0;
  bit  quiet           = 1'b0;  // no idling on either side
  bit  hold_go         = 1'b0;
  bit  hold_used       = 1'b0;
  int  hold_left       = 0;

  pix_t corner_frame [25] = '{
    8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd7,   8'd7,   8'd7,   8'd7,   8'd7,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd255, 8'd0,   8'd128, 8'd1,   8'd254
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_W) return MAX_W;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
    return cfg_height;
  endfunction

  // Advance the window by one pixel; queue a result for interior centers
  task automatic predict_pixel(input pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned slot;
    pix_t        sorted [WIN_N];
    pix_t        v;
    pix_t        lo;
    pix_t        hi;
    pix_t        mid;
    int          a;
    int          b;
    int          n;
    binarized_t  res;
    w = eff_width();
    h = eff_height();
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;

    for (a = 0; a < WIN_D; a++)
      for (b = 0; b < WIN_D - 1; b++)
        win_regs[a][b] = win_regs[a][b+1];
    slot = row_pos % LINE_ROWS;
    for (a = 0; a < LINE_ROWS; a++)
      win_regs[a][WIN_D-1] = line_mem[(slot + a) % LINE_ROWS][col_pos];
    win_regs[WIN_D-1][WIN_D-1] = px;
    line_mem[slot][col_pos] = px;

    if (row_pos >= LINE_ROWS && col_pos >= LINE_ROWS) begin
      n  = 0;
      lo = win_regs[0][0];
      hi = win_regs[0][0];
      for (a = 0; a < WIN_D; a++)
        for (b = 0; b < WIN_D; b++) begin
          v = win_regs[a][b];
          sorted[n] = v;
          n++;
          if (v > hi) hi = v;
          if (v < lo) lo = v;
        end
      // insertion sort, median is the middle sample
      for (a = 1; a < WIN_N; a++) begin
        v = sorted[a];
        b = a - 1;
        while (b >= 0 && sorted[b] > v) begin
          sorted[b+1] = sorted[b];
          b--;
        end
        sorted[b+1] = v;
      end
      mid = sorted[WIN_N/2];
      res.pix       = (win_regs[WIN_R][WIN_R] >= mid) ? hi : lo;
      res.frame_end = (row_pos == h - 1 && col_pos == w - 1);
      expected_q.push_back(res);
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Pixel driver: idle bursts, calm stretches, holds a stalled transfer
  int send_gap  = 0;
  int send_calm = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap  = 0;
      send_calm = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_pixel(pixel_in);
        pixels_sent++;
      end
      if (send_calm != 0) send_calm--;
      if (in_valid && in_stall) begin
        // stalled transfer keeps its payload
      end else if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (!quiet && hold_left == 0 && send_calm == 0 &&
                   $urandom_range(0, 11) == 0) begin
        in_valid <= 1'b0;
        send_gap = $urandom_range(0, 12);
        if ($urandom_range(0, 2) == 0) send_calm = $urandom_range(30, 300);
      end else if (pixel_q.size() != 0) begin
        in_valid <= 1'b1;
        pixel_in <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, armed once from the stimulus
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go && !hold_used) begin
      hold_left <= 400;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and stall generator
  int recv_gap  = 0;
  int recv_calm = 0;
  always @(posedge clk) begin
    binarized_t exp_res;
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap  = 0;
      recv_calm = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result pixel_out=%0d frame_last=%0b",
                     $realtime, pixel_out, frame_last);
          mismatches++;
        end else begin
          exp_res = expected_q.pop_front();
          results_checked++;
          if (pixel_out !== exp_res.pix || frame_last !== exp_res.frame_end) begin
            if (mismatches < 10)
              $display("%0t: result %0d expected pixel=%0d last=%0b, got pixel=%0d last=%0b",
                       $realtime, results_checked, exp_res.pix, exp_res.frame_end,
                       pixel_out, frame_last);
            mismatches++;
          end
        end
      end
      if (recv_calm != 0) recv_calm--;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (recv_gap != 0) begin
        out_stall <= 1'b1;
        recv_gap--;
      end else if (!quiet && recv_calm == 0 && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        recv_gap = $urandom_range(0, 12);
        if ($urandom_range(0, 2) == 0) recv_calm = $urandom_range(30, 300);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Register write, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) cfg_width = data[WIDTH_W-1:0];
    else cfg_height = data[HEIGHT_W-1:0];
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
  endtask

  function automatic pix_t gen_pixel(input pattern_t pat, input int unsigned idx);
    case (pat)
      PAT_TIES:     return pix_t'($urandom_range(0, 3));
      PAT_BINARY:   return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      PAT_GRADIENT: return pix_t'(idx * 3 + $urandom_range(0, 6));
      default:      return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Queue whole frames at the current size
  task automatic push_frames(input int nframes, input pattern_t pat);
    int unsigned total;
    int unsigned i;
    total = eff_width() * eff_height() * nframes;
    @(negedge clk);
    for (i = 0; i < total; i++) pixel_q.push_back(gen_pixel(pat, i));
    frames_sent += nframes;
  endtask

  // Wait until every pixel is taken and every result is back, then let the pipe empty
  task automatic wait_idle();
    @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Stimulus sequence
  initial begin
    int random_pixels;
    int w;
    int h;
    int pick;
    for (int a = 0; a < LINE_ROWS; a++)
      for (int c = 0; c < MAX_W; c++) line_mem[a][c] = '0;
    for (int a = 0; a < WIN_D; a++)
      for (int b = 0; b < WIN_D; b++) win_regs[a][b] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // 5x5 frame with extreme values and ties
    set_size(5, 5);
    @(negedge clk);
    foreach (corner_frame[i]) pixel_q.push_back(corner_frame[i]);
    frames_sent++;
    wait_idle();

    // zero sizes clamp to a 1x1 frame: no results
    set_size(0, 0);
    @(negedge clk);
    pixel_q.push_back(8'd255);
    pixel_q.push_back(8'd0);
    pixel_q.push_back(8'd255);
    frames_sent += 3;
    wait_idle();

    // frames too narrow or too short for any interior pixel
    set_size(2, 7);
    push_frames(1, PAT_UNIFORM);
    wait_idle();
    set_size(7, 2);
    push_frames(1, PAT_BINARY);
    wait_idle();

    // oversized width clamps to the full line: part of the first row, then a
    // narrower size makes the next pixel open row one of a 5x5 frame
    set_size(2047, 3);
    @(negedge clk);
    for (int i = 0; i < 40; i++) pixel_q.push_back(gen_pixel(PAT_GRADIENT, i));
    wait_idle();
    set_size(5, 5);
    @(negedge clk);
    for (int i = 0; i < 20; i++) pixel_q.push_back(gen_pixel(PAT_UNIFORM, i));
    frames_sent++;
    wait_idle();

    // oversized height clamps to 4096 rows: five rows, then a new frame starts;
    // the receiver holds off meanwhile so the pipeline fills and stalls
    set_size(5, 8191);
    @(negedge clk);
    for (int i = 0; i < 25; i++) pixel_q.push_back(gen_pixel(PAT_TIES, i));
    frames_sent++;
    hold_go = 1'b1;
    wait_idle();
    set_size(5, 5);
    push_frames(1, PAT_BINARY);
    wait_idle();

    // random sizes and content, whole frames only
    random_pixels = pixels_sent;
    while (pixels_sent - random_pixels < 300) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) w = $urandom_range(0, 4);
      else if (pick == 1) w = $urandom_range(25, 40);
      else w = $urandom_range(5, 16);
      pick = $urandom_range(0, 9);
      h = (pick == 0) ? $urandom_range(0, 4) : $urandom_range(5, 8);
      set_size(w, h);
      push_frames(1, pattern_t'($urandom_range(0, 3)));
      wait_idle();
    end

    // closing stretch at full rate on both sides
    quiet = 1'b1;
    set_size($urandom_range(5, 16), $urandom_range(5, 8));
    push_frames(2, PAT_UNIFORM);
    wait_idle();

    $display("Covered %0d frames, %0d pixels in, %0d binarized results checked,",
             frames_sent, pixels_sent, results_checked);
    $display("sizes from clamped 1x1 to oversized width and height, one long output hold.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d results outstanding", expected_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
